@@ src/line_follow_robot_motor_controller_assert.svh @@
// Assertion macros for the motor controller.
`ifndef LINE_FOLLOW_ROBOT_MOTOR_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_ROBOT_MOTOR_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define LFR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LFR_ASSERT(lbl, cond, msg)
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/lfr_pkg.sv @@
package lfr_pkg;

  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_FOLLOW = 2'd1;
  localparam logic [1:0] MODE_DANCE  = 2'd2;

  localparam logic [1:0] LED_DARK  = 2'd0;
  localparam logic [1:0] LED_SIDE1 = 2'd1;
  localparam logic [1:0] LED_SIDE2 = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [2:0] CFG_LINE_THRESHOLD    = 3'd0;
  localparam logic [2:0] CFG_SPEED_SLOW        = 3'd1;
  localparam logic [2:0] CFG_SPEED_SLOW_MEDIUM = 3'd2;
  localparam logic [2:0] CFG_SPEED_MEDIUM      = 3'd3;
  localparam logic [2:0] CFG_SPEED_FAST        = 3'd4;
  localparam logic [2:0] CFG_LED_PERIOD        = 3'd5;

  localparam logic [7:0] RST_LINE_THRESHOLD    = 8'd235;
  localparam logic [9:0] RST_SPEED_SLOW        = 10'd750;
  localparam logic [9:0] RST_SPEED_SLOW_MEDIUM = 10'd800;
  localparam logic [9:0] RST_SPEED_MEDIUM      = 10'd850;
  localparam logic [9:0] RST_SPEED_FAST        = 10'd1000;
  localparam logic [7:0] RST_LED_PERIOD        = 8'd10;

  localparam int DEF_DANCE_TURN_AT  = 100;
  localparam int DEF_DANCE_HALT_AT  = 200;
  localparam int DEF_DANCE_SPIN_AT  = 250;
  localparam int DEF_DANCE_PIVOT_AT = 450;
  localparam int DEF_DANCE_END_AT   = 600;

  // flag bits
  localparam int FL_LEFT_LAST  = 0;
  localparam int FL_LEFT2      = 1;
  localparam int FL_LEFT1      = 2;
  localparam int FL_RIGHT1     = 3;
  localparam int FL_RIGHT2     = 4;
  localparam int FL_RIGHT_LAST = 5;

  typedef struct packed {
    logic [7:0] line_threshold;
    logic [9:0] speed_slow;
    logic [9:0] speed_slow_medium;
    logic [9:0] speed_medium;
    logic [9:0] speed_fast;
    logic [7:0] led_period_eff;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        button_latch;
    logic [1:0]  channel;
    logic [5:0]  line_flags;
    logic [15:0] dance_ticks;
    logic [7:0]  led_ticks;
    logic [7:0]  led_rem;
    logic [9:0]  left_duty;
    logic [9:0]  right_duty;
    logic        forward;
    logic [1:0]  led;
  } state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] sample;
    logic       button_pressed;
  } item_t;

endpackage

@@ src/lfr_rem.sv @@
module lfr_rem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       busy,
  output logic       done,
  output logic [7:0] rem
);

  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [8:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    done     = 1'b0;
    trial    = {rem_r, dividend[cnt_r]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd7;
      rem_nxt  = 8'd0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 8'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[7:0];
      end
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_nxt;

endmodule

@@ src/lfr_core.sv @@
module lfr_core #(
  parameter int DANCE_TURN_AT  = lfr_pkg::DEF_DANCE_TURN_AT,
  parameter int DANCE_HALT_AT  = lfr_pkg::DEF_DANCE_HALT_AT,
  parameter int DANCE_SPIN_AT  = lfr_pkg::DEF_DANCE_SPIN_AT,
  parameter int DANCE_PIVOT_AT = lfr_pkg::DEF_DANCE_PIVOT_AT,
  parameter int DANCE_END_AT   = lfr_pkg::DEF_DANCE_END_AT
) (
  input  lfr_pkg::item_t  item,
  input  lfr_pkg::cfg_t   cfg,
  input  lfr_pkg::state_t st,
  output lfr_pkg::state_t nxt
);

  localparam logic [15:0] TURN_AT  = 16'(DANCE_TURN_AT);
  localparam logic [15:0] HALT_AT  = 16'(DANCE_HALT_AT);
  localparam logic [15:0] SPIN_AT  = 16'(DANCE_SPIN_AT);
  localparam logic [15:0] PIVOT_AT = 16'(DANCE_PIVOT_AT);
  localparam logic [15:0] END_AT   = 16'(DANCE_END_AT);

  logic [5:0] mask;
  logic [5:0] f;
  logic [8:0] rem_inc;
  logic [15:0] t;

  always_comb begin
    nxt     = st;
    mask    = 6'd0;
    f       = st.line_flags;
    rem_inc = {1'b0, st.led_rem} + 9'd1;
    t       = st.dance_ticks;
    case (st.channel)
      2'd0:    mask[lfr_pkg::FL_RIGHT2] = 1'b1;
      2'd1:    mask[lfr_pkg::FL_RIGHT1] = 1'b1;
      2'd2:    mask[lfr_pkg::FL_LEFT1]  = 1'b1;
      default: mask[lfr_pkg::FL_LEFT2]  = 1'b1;
    endcase

    if (item.func == lfr_pkg::FUNC_SAMPLE) begin
      if (st.mode == lfr_pkg::MODE_STOP) begin
        nxt.left_duty  = 10'd0;
        nxt.right_duty = 10'd0;
      end else if (st.mode == lfr_pkg::MODE_FOLLOW) begin
        nxt.forward = 1'b1;
        if (item.sample > cfg.line_threshold) begin
          f = f | mask;
          if (st.channel[1]) begin
            f[lfr_pkg::FL_LEFT_LAST]  = 1'b1;
            f[lfr_pkg::FL_RIGHT_LAST] = 1'b0;
          end else begin
            f[lfr_pkg::FL_RIGHT_LAST] = 1'b1;
            f[lfr_pkg::FL_LEFT_LAST]  = 1'b0;
          end
        end else begin
          f = f & ~mask;
        end
        nxt.line_flags = f;
        if (f[lfr_pkg::FL_LEFT2]) begin
          nxt.left_duty  = cfg.speed_slow;
          nxt.right_duty = cfg.speed_medium;
        end else if (f[lfr_pkg::FL_LEFT1] && f[lfr_pkg::FL_RIGHT1]) begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = cfg.speed_medium;
        end else if (f[lfr_pkg::FL_LEFT1]) begin
          nxt.left_duty  = cfg.speed_slow_medium;
          nxt.right_duty = cfg.speed_medium;
        end else if (f[lfr_pkg::FL_RIGHT1]) begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = cfg.speed_slow_medium;
        end else if (f[lfr_pkg::FL_RIGHT2]) begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = cfg.speed_slow;
        end else if (f[lfr_pkg::FL_LEFT_LAST]) begin
          nxt.left_duty  = 10'd0;
          nxt.right_duty = cfg.speed_medium;
        end else if (f[lfr_pkg::FL_RIGHT_LAST]) begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = 10'd0;
        end else begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = cfg.speed_medium;
        end
      end
      nxt.channel = st.channel + 2'd1;
    end else begin
      if (item.button_pressed) begin
        nxt.button_latch = 1'b1;
      end else if (st.button_latch) begin
        nxt.button_latch = 1'b0;
        case (st.mode)
          lfr_pkg::MODE_STOP: begin
            nxt.mode    = lfr_pkg::MODE_FOLLOW;
            nxt.channel = 2'd0;
          end
          lfr_pkg::MODE_FOLLOW: begin
            nxt.mode        = lfr_pkg::MODE_DANCE;
            nxt.forward     = 1'b1;
            nxt.dance_ticks = 16'd0;
          end
          default: nxt.mode = lfr_pkg::MODE_STOP;
        endcase
      end

      if (nxt.mode == lfr_pkg::MODE_DANCE) begin
        t = nxt.dance_ticks;
        if (t == 16'd0) begin
          nxt.left_duty  = cfg.speed_medium;
          nxt.right_duty = cfg.speed_medium;
        end else if (t == TURN_AT) begin
          nxt.left_duty  = 10'd0;
          nxt.right_duty = cfg.speed_medium;
        end else if (t == HALT_AT) begin
          nxt.left_duty  = 10'd0;
          nxt.right_duty = 10'd0;
        end else if (t == SPIN_AT) begin
          nxt.left_duty  = cfg.speed_fast;
          nxt.right_duty = cfg.speed_medium;
        end else if (t == PIVOT_AT) begin
          nxt.left_duty  = cfg.speed_fast;
          nxt.right_duty = 10'd0;
        end
        if (t >= END_AT) begin
          nxt.left_duty  = 10'd0;
          nxt.right_duty = 10'd0;
        end
        nxt.dance_ticks = t + 16'd1;
      end

      // led_rem tracks led_ticks modulo the period
      if (st.led_rem == 8'd0) begin
        nxt.led = (st.led == lfr_pkg::LED_SIDE2) ? lfr_pkg::LED_SIDE1 : lfr_pkg::LED_SIDE2;
      end
      nxt.led_ticks = st.led_ticks + 8'd1;
      if (st.led_ticks == 8'hFF || rem_inc == {1'b0, cfg.led_period_eff}) begin
        nxt.led_rem = 8'd0;
      end else begin
        nxt.led_rem = rem_inc[7:0];
      end
    end
  end

endmodule

@@ src/line_follow_robot_motor_controller.sv @@
// An input transfer is captured in the input register, and its result in the result register.
// Throughput: one item per cycle while out_tready is high and no led_period write is busy.
// After a write to led_period, in_tready and cfg_ready are low while the bit-serial
// remainder of the LED tick count by the new period is computed.
// Reset: synchronous active-low rst_n; state, settings and valids to reset values.
module line_follow_robot_motor_controller #(
  parameter int DANCE_TURN_AT  = lfr_pkg::DEF_DANCE_TURN_AT,
  parameter int DANCE_HALT_AT  = lfr_pkg::DEF_DANCE_HALT_AT,
  parameter int DANCE_SPIN_AT  = lfr_pkg::DEF_DANCE_SPIN_AT,
  parameter int DANCE_PIVOT_AT = lfr_pkg::DEF_DANCE_PIVOT_AT,
  parameter int DANCE_END_AT   = lfr_pkg::DEF_DANCE_END_AT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // sample[7:0], button_pressed[8], zero pad
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_speed[9:0], right_speed[19:10], drive_forward[20], led_state[22:21],
  // mode_now[24:23], sensor_channel[26:25], zero pad
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  `include "line_follow_robot_motor_controller_assert.svh"

  logic [7:0] line_threshold_r;
  logic [9:0] speed_slow_r, speed_slow_medium_r, speed_medium_r, speed_fast_r;
  logic [7:0] led_period_r;

  lfr_pkg::cfg_t   cfg;
  lfr_pkg::state_t st_r, st_nxt;
  lfr_pkg::item_t  item_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic [31:0]     out_data_r;
  logic            adv;
  logic            cfg_xfer;
  logic            rem_start, rem_busy, rem_done;
  logic [7:0]      rem_val;

  assign cfg.line_threshold    = line_threshold_r;
  assign cfg.speed_slow        = speed_slow_r;
  assign cfg.speed_slow_medium = speed_slow_medium_r;
  assign cfg.speed_medium      = speed_medium_r;
  assign cfg.speed_fast        = speed_fast_r;
  assign cfg.led_period_eff    = (led_period_r == 8'd0) ? 8'd1 : led_period_r;

  assign cfg_ready = !rem_busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign rem_start = cfg_xfer && (cfg_index == lfr_pkg::CFG_LED_PERIOD);

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !rem_busy && (!in_valid_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_threshold_r    <= lfr_pkg::RST_LINE_THRESHOLD;
      speed_slow_r        <= lfr_pkg::RST_SPEED_SLOW;
      speed_slow_medium_r <= lfr_pkg::RST_SPEED_SLOW_MEDIUM;
      speed_medium_r      <= lfr_pkg::RST_SPEED_MEDIUM;
      speed_fast_r        <= lfr_pkg::RST_SPEED_FAST;
      led_period_r        <= lfr_pkg::RST_LED_PERIOD;
    end else if (cfg_xfer) begin
      case (cfg_index)
        lfr_pkg::CFG_LINE_THRESHOLD:    line_threshold_r    <= cfg_data[7:0];
        lfr_pkg::CFG_SPEED_SLOW:        speed_slow_r        <= cfg_data;
        lfr_pkg::CFG_SPEED_SLOW_MEDIUM: speed_slow_medium_r <= cfg_data;
        lfr_pkg::CFG_SPEED_MEDIUM:      speed_medium_r      <= cfg_data;
        lfr_pkg::CFG_SPEED_FAST:        speed_fast_r        <= cfg_data;
        lfr_pkg::CFG_LED_PERIOD:        led_period_r        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lfr_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (st_r.led_ticks),
    .divisor  (cfg.led_period_eff),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  lfr_core #(
    .DANCE_TURN_AT  (DANCE_TURN_AT),
    .DANCE_HALT_AT  (DANCE_HALT_AT),
    .DANCE_SPIN_AT  (DANCE_SPIN_AT),
    .DANCE_PIVOT_AT (DANCE_PIVOT_AT),
    .DANCE_END_AT   (DANCE_END_AT)
  ) u_core (
    .item (item_r),
    .cfg  (cfg),
    .st   (st_r),
    .nxt  (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        st_r <= st_nxt;
      end else if (rem_done) begin
        st_r.led_rem <= rem_val;
      end
    end
    if (in_tready && in_tvalid) begin
      item_r.func           <= in_tuser;
      item_r.sample         <= in_tdata[7:0];
      item_r.button_pressed <= in_tdata[8];
    end
    if (adv) begin
      out_data_r <= {5'd0, st_nxt.channel, st_nxt.mode, st_nxt.led, st_nxt.forward,
                     st_nxt.right_duty, st_nxt.left_duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LFR_ASSERT(a_busy_blocks_input, !(rem_busy && in_tready), "input taken during remainder")
  `LFR_ASSERT(a_rem_in_range, rem_busy || (st_r.led_rem < cfg.led_period_eff), "bad led remainder")
  `LFR_ASSERT(a_mode_legal, st_r.mode != 2'd3, "illegal mode")
  `LFR_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "result lost")

endmodule

@@ tb/line_follow_robot_motor_controller_test.sv @@
module line_follow_robot_motor_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfr_pkg::*;

  localparam int STALL_LIMIT     = 1000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int NUM_PHASES      = 4;
  localparam int LONG_DANCE_PH   = 3;
  localparam int LONG_DANCE_TICKS = 610;

  // packed so that the last field sits in the lowest bits of out_tdata
  typedef struct packed {
    logic [1:0] sensor_channel;
    logic [1:0] mode_now;
    logic [1:0] led_state;
    logic       drive_forward;
    logic [9:0] right_speed;
    logic [9:0] left_speed;
  } motor_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  line_follow_robot_motor_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #1 clk = ~clk;

  // controller copy: settings
  logic [7:0] thr_q     = RST_LINE_THRESHOLD;
  logic [9:0] slow_q    = RST_SPEED_SLOW;
  logic [9:0] slowmed_q = RST_SPEED_SLOW_MEDIUM;
  logic [9:0] medium_q  = RST_SPEED_MEDIUM;
  logic [9:0] fast_q    = RST_SPEED_FAST;
  logic [7:0] led_per_q = RST_LED_PERIOD;
  // controller copy: state
  logic [1:0]  mode_q      = MODE_STOP;
  logic        latch_q     = 1'b0;
  logic [1:0]  chan_q      = '0;
  logic [5:0]  flags_q     = '0;
  logic [15:0] dance_q     = '0;
  logic [7:0]  led_ticks_q = '0;
  logic [9:0]  left_q      = '0;
  logic [9:0]  right_q     = '0;
  logic        fwd_q       = 1'b0;
  logic [1:0]  led_q       = LED_DARK;

  item_t         event_queue[$];
  motor_status_t expected_status[$];
  item_t         cur_event;

  // stimulus-side view of mode and button latch
  logic [1:0] plan_mode = MODE_STOP;
  logic       plan_latch = 1'b0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_cfg = 0;
  int idle_pct = 10;
  int in_hold = 0;
  int out_hold = 0;
  int stall_cycles = 0;

  function automatic void set_duty(logic [9:0] l, logic [9:0] r);
    left_q = l;
    right_q = r;
  endfunction

  function automatic void step_controller(item_t ev);
    logic [5:0] f;
    int chan_bit;
    int per;
    if (ev.func == FUNC_SAMPLE) begin
      if (mode_q == MODE_STOP) begin
        set_duty('0, '0);
      end else if (mode_q == MODE_FOLLOW) begin
        case (chan_q)
          2'd0: chan_bit = FL_RIGHT2;
          2'd1: chan_bit = FL_RIGHT1;
          2'd2: chan_bit = FL_LEFT1;
          default: chan_bit = FL_LEFT2;
        endcase
        f = flags_q;
        fwd_q = 1'b1;
        if (ev.sample > thr_q) begin
          f[chan_bit] = 1'b1;
          f[FL_LEFT_LAST] = chan_q[1];
          f[FL_RIGHT_LAST] = !chan_q[1];
        end else begin
          f[chan_bit] = 1'b0;
        end
        flags_q = f;
        if (f[FL_LEFT2]) set_duty(slow_q, medium_q);
        else if (f[FL_LEFT1] && f[FL_RIGHT1]) set_duty(medium_q, medium_q);
        else if (f[FL_LEFT1]) set_duty(slowmed_q, medium_q);
        else if (f[FL_RIGHT1]) set_duty(medium_q, slowmed_q);
        else if (f[FL_RIGHT2]) set_duty(medium_q, slow_q);
        else if (f[FL_LEFT_LAST]) set_duty('0, medium_q);
        else if (f[FL_RIGHT_LAST]) set_duty(medium_q, '0);
        else set_duty(medium_q, medium_q);
      end
      chan_q = chan_q + 2'd1;
    end else begin
      if (ev.button_pressed) begin
        latch_q = 1'b1;
      end else if (latch_q) begin
        latch_q = 1'b0;
        case (mode_q)
          MODE_STOP: begin
            mode_q = MODE_FOLLOW;
            chan_q = '0;
          end
          MODE_FOLLOW: begin
            mode_q = MODE_DANCE;
            fwd_q = 1'b1;
            dance_q = '0;
          end
          default: mode_q = MODE_STOP;
        endcase
      end
      if (mode_q == MODE_DANCE) begin
        if (dance_q == 0) set_duty(medium_q, medium_q);
        else if (dance_q == DEF_DANCE_TURN_AT) set_duty('0, medium_q);
        else if (dance_q == DEF_DANCE_HALT_AT) set_duty('0, '0);
        else if (dance_q == DEF_DANCE_SPIN_AT) set_duty(fast_q, medium_q);
        else if (dance_q == DEF_DANCE_PIVOT_AT) set_duty(fast_q, '0);
        if (dance_q >= DEF_DANCE_END_AT) set_duty('0, '0);
        dance_q = dance_q + 16'd1;
      end
      per = (led_per_q == 0) ? 1 : led_per_q;
      if (led_ticks_q % per == 0) led_q = (led_q == LED_SIDE2) ? LED_SIDE1 : LED_SIDE2;
      led_ticks_q = led_ticks_q + 8'd1;
    end
    expected_status.push_back('{left_speed: left_q, right_speed: right_q, drive_forward: fwd_q,
                                led_state: led_q, mode_now: mode_q, sensor_channel: chan_q});
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    item_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_controller(cur_event);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_hold > 0) begin
          in_hold <= in_hold - 1;
          in_tvalid <= 1'b0;
        end else if (event_queue.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_hold <= $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          ev = event_queue.pop_front();
          cur_event <= ev;
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, ev.button_pressed, ev.sample};
          in_tuser <= ev.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    motor_status_t got;
    motor_status_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[26:0];
        n_results++;
        if (expected_status.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
          n_errors++;
        end else begin
          want = expected_status.pop_front();
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("right_speed", want.right_speed, got.right_speed);
          check_field("drive_forward", want.drive_forward, got.drive_forward);
          check_field("led_state", want.led_state, got.led_state);
          check_field("mode_now", want.mode_now, got.mode_now);
          check_field("sensor_channel", want.sensor_channel, got.sensor_channel);
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_hold <= $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void queue_event(logic func, logic [7:0] sample, logic button);
    item_t ev;
    ev.func = func;
    ev.sample = sample;
    ev.button_pressed = button;
    event_queue.push_back(ev);
    n_queued++;
    if (func == FUNC_TICK) begin
      if (button) begin
        plan_latch = 1'b1;
      end else if (plan_latch) begin
        plan_latch = 1'b0;
        plan_mode = (plan_mode == MODE_DANCE) ? MODE_STOP : plan_mode + 2'd1;
      end
    end
  endfunction

  function automatic void queue_sample(logic [7:0] sample);
    queue_event(FUNC_SAMPLE, sample, 1'($urandom_range(0, 1)));
  endfunction

  function automatic void queue_tick(logic button);
    queue_event(FUNC_TICK, 8'($urandom_range(0, 255)), button);
  endfunction

  function automatic logic [7:0] line_level();
    case ($urandom_range(0, 3))
      0: return 8'(thr_q + 8'($urandom_range(0, 1)));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // press and release the button until the planned mode is reached
  function automatic void enter_mode(logic [1:0] target);
    if (plan_latch) queue_tick(1'b0);
    while (plan_mode != target) begin
      repeat ($urandom_range(1, 3)) begin
        queue_tick(1'b1);
        if ($urandom_range(0, 3) == 0) queue_sample(8'($urandom_range(0, 255)));
      end
      queue_tick(1'b0);
    end
  endfunction

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_LINE_THRESHOLD:    thr_q = val[7:0];
      CFG_SPEED_SLOW:        slow_q = val;
      CFG_SPEED_SLOW_MEDIUM: slowmed_q = val;
      CFG_SPEED_MEDIUM:      medium_q = val;
      CFG_SPEED_FAST:        fast_q = val;
      CFG_LED_PERIOD:        led_per_q = val[7:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [9:0] thr, slow, slowmed, med, fast, per;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // stop mode zeroes duties, then into line follow
    queue_sample(8'd255);
    queue_tick(1'b1);
    queue_tick(1'b0);
    // nothing seen yet, right1, both inner, threshold itself is not a line
    queue_sample(8'd0);
    queue_sample(8'd255);
    queue_sample(8'd236);
    queue_sample(8'd235);
    // left1 only, last side left, left2
    queue_sample(8'd0);
    queue_sample(8'd0);
    queue_sample(8'd0);
    queue_sample(8'd255);
    // left2 wins over right2, then right2, then last side right
    queue_sample(8'd255);
    queue_sample(8'd0);
    queue_sample(8'd0);
    queue_sample(8'd0);
    queue_sample(8'd0);
    // held button, then dance; samples leave dance duties alone
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_sample(8'd128);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_sample(8'd17);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          thr = 10'd0; slow = 10'd0; slowmed = 10'd0; med = 10'd1023; fast = 10'd1023;
          per = 10'd0;
        end
        1: begin
          thr = 10'd255; slow = 10'd1023; slowmed = 10'd1023; med = 10'd0; fast = 10'd0;
          per = 10'd255;
        end
        default: begin
          thr = 10'($urandom_range(0, 255));
          slow = 10'($urandom_range(0, 1023));
          slowmed = 10'($urandom_range(0, 1023));
          med = 10'($urandom_range(0, 1023));
          fast = 10'($urandom_range(0, 1023));
          per = 10'($urandom_range(1, 12));
        end
      endcase
      write_reg(CFG_LINE_THRESHOLD, thr);
      write_reg(CFG_SPEED_SLOW, slow);
      write_reg(CFG_SPEED_SLOW_MEDIUM, slowmed);
      write_reg(CFG_SPEED_MEDIUM, med);
      write_reg(CFG_SPEED_FAST, fast);
      write_reg(CFG_LED_PERIOD, per);

      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 5;
        default: idle_pct = 15;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;

      repeat (2) begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            enter_mode(MODE_FOLLOW);
            repeat ($urandom_range(16, 48)) begin
              if ($urandom_range(0, 7) == 0) queue_tick(1'b0);
              else queue_sample(line_level());
            end
          end
          3: begin
            enter_mode(MODE_DANCE);
            repeat ($urandom_range(10, 40)) begin
              if ($urandom_range(0, 5) == 0) queue_sample(8'($urandom_range(0, 255)));
              else queue_tick(1'b0);
            end
          end
          4: begin
            enter_mode(MODE_STOP);
            repeat ($urandom_range(4, 10)) queue_event(1'($urandom_range(0, 1)),
                                                       8'($urandom_range(0, 255)), 1'b0);
          end
          default: begin
            repeat ($urandom_range(6, 14)) queue_event(1'($urandom_range(0, 1)),
                                                       8'($urandom_range(0, 255)),
                                                       1'($urandom_range(0, 1)));
          end
        endcase
      end

      // full dance schedule, past its end, with the LED tick count wrapping
      if (p == LONG_DANCE_PH) begin
        enter_mode(MODE_DANCE);
        repeat (LONG_DANCE_TICKS) begin
          if ($urandom_range(0, 31) == 0) queue_sample(8'($urandom_range(0, 255)));
          queue_tick(1'b0);
        end
      end
      wait_drained();
    end

    $display("Covered %0d events and %0d checked results across %0d register writes.",
             n_accepted, n_results, n_cfg);
    $display("Modes stop, follow and dance, full dance schedule, threshold and speed extremes.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
